[hw/rtl/smp_pkg.sv]
package smp_pkg;

  // One input item: a message byte and/or the end-of-message mark.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       is_end;
  } in_item_t;

  // One result item: a 64-bit block word with its position flags.
  typedef struct packed {
    logic [63:0] word_out;
    logic        block_end;
    logic        message_end;
  } out_item_t;

  // Depth of the command queue between the front and the back.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // Padding constants.
  localparam logic [7:0] PadMark   = 8'h80;
  localparam logic [2:0] LastWord  = 3'd7;
  localparam logic [2:0] LenPrev   = 3'd6;
  localparam int unsigned TotalW   = 61;

endpackage

[hw/rtl/smp_front.sv]
module smp_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  smp_pkg::in_item_t item_i,
  output logic             cmd_valid_o,
  input  logic             cmd_ready_i,
  output smp_pkg::in_item_t cmd_o
);
  import smp_pkg::*;

  in_item_t               entry_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0]   count_q, count_d;
  logic                   accept;
  logic                   keep;
  logic                   do_wr;
  logic                   do_rd;

  // Items that carry neither a byte nor an end mark do nothing and are dropped here.
  assign accept = push && !full;
  assign keep   = item_i.has_byte || item_i.is_end;
  assign do_wr  = accept && keep;
  assign do_rd  = cmd_valid_o && cmd_ready_i;

  assign full        = (count_q == QueueCntW'(QueueDepth));
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_d = count_q + 1'b1;
    end else if (!do_wr && do_rd) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

[hw/rtl/smp_back.sv]
module smp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  smp_pkg::in_item_t  cmd_i,
  output logic              empty,
  input  logic              pop,
  output smp_pkg::out_item_t item_o
);
  import smp_pkg::*;

  typedef enum logic [3:0] {
    StRun  = 4'b0001,
    StMark = 4'b0010,
    StZero = 4'b0100,
    StLen  = 4'b1000
  } pad_state_e;

  pad_state_e        state_q, state_d;
  logic [TotalW-1:0] total_q, total_d;
  logic [63:0]       acc_q, acc_d;
  logic [2:0]        biw_q, biw_d;
  logic [2:0]        wib_q, wib_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;
  logic              slot_free;
  logic              emit;
  out_item_t         emit_item;
  logic [6:0]        acc_shift;
  logic [6:0]        mark_shift;
  logic [63:0]       mark_word;

  assign slot_free   = !out_valid_q || pop;
  assign cmd_ready_o = (state_q == StRun) && slot_free;

  // Close the partial word: left-align the held bytes and put the pad mark after them.
  assign acc_shift  = {4'd8 - {1'b0, biw_q}, 3'b000};
  assign mark_shift = {4'd7 - {1'b0, biw_q}, 3'b000};
  assign mark_word  = (acc_q << acc_shift) | ({56'd0, PadMark} << mark_shift);

  always_comb begin
    state_d   = state_q;
    total_d   = total_q;
    acc_d     = acc_q;
    biw_d     = biw_q;
    wib_d     = wib_q;
    emit      = 1'b0;
    emit_item = '0;
    unique case (state_q)
      StRun: begin
        if (cmd_valid_i && slot_free) begin
          if (cmd_i.has_byte) begin
            acc_d   = {acc_q[55:0], cmd_i.data_byte};
            biw_d   = biw_q + 3'd1;
            total_d = total_q + 1'b1;
            if (biw_q == LastWord) begin
              emit                = 1'b1;
              emit_item.word_out  = {acc_q[55:0], cmd_i.data_byte};
              emit_item.block_end = (wib_q == LastWord);
              acc_d               = '0;
              wib_d               = wib_q + 3'd1;
            end
          end
          if (cmd_i.is_end) begin
            state_d = StMark;
          end
        end
      end
      StMark: begin
        if (slot_free) begin
          emit                = 1'b1;
          emit_item.word_out  = mark_word;
          emit_item.block_end = (wib_q == LastWord);
          acc_d               = '0;
          biw_d               = '0;
          wib_d               = wib_q + 3'd1;
          state_d             = (wib_q == LenPrev) ? StLen : StZero;
        end
      end
      StZero: begin
        if (slot_free) begin
          emit    = 1'b1;
          wib_d   = wib_q + 3'd1;
          state_d = (wib_q == LenPrev) ? StLen : StZero;
        end
      end
      StLen: begin
        if (slot_free) begin
          emit                  = 1'b1;
          emit_item.word_out    = {total_q, 3'b000};
          emit_item.block_end   = 1'b1;
          emit_item.message_end = 1'b1;
          total_d               = '0;
          acc_d                 = '0;
          biw_d                 = '0;
          wib_d                 = '0;
          state_d               = StRun;
        end
      end
      default: begin
        state_d = StRun;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !pop;
    out_d       = out_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_d       = emit_item;
    end
  end

  assign empty  = !out_valid_q;
  assign item_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StRun;
      total_q     <= '0;
      acc_q       <= '0;
      biw_q       <= '0;
      wib_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      acc_q       <= acc_d;
      biw_q       <= biw_d;
      wib_q       <= wib_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule

[hw/rtl/sha256_message_padder.sv]
// SHA-256 message padder. Bytes of a message enter one item at a time; an
// item may carry a byte, an end mark, or both, so empty and block-aligned
// messages are handled. Bytes are packed into 64-bit words, first byte in the
// most significant position, and each full word leaves as one result item.
// After the end mark the block appends the byte 0x80, zero bytes up to byte
// 56 of the block and the message length in bits as a 64-bit big-endian word
// (byte count times 8, wrapping modulo 2^64); when the mark lands in the last
// eight bytes of a block a whole extra block of padding follows. Every result
// carries block_end on the eighth word of a block and message_end on the last
// word of the padded message, after which the next item starts a new message.
// A byte item is taken every cycle while results are drained. Once an end item
// is taken, the padding engine emits two to nine padding words, one word per
// cycle while results are drained, into a single output register. The two-entry
// command queue takes up to two more items during that time; after that full
// stays high until the engine returns to packing.
module sha256_message_padder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  smp_pkg::in_item_t   item_i,
  output logic               empty,
  input  logic               pop,
  output smp_pkg::out_item_t  item_o
);
  import smp_pkg::*;

  logic     cmd_valid;
  logic     cmd_ready;
  in_item_t cmd;

  // The front takes items and drops those that carry nothing.
  smp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .item_i      (item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  // The back packs bytes and generates the padding words.
  smp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .empty       (empty),
    .pop         (pop),
    .item_o      (item_o)
  );

endmodule

[hw/rtl/smp_checker.sv]
module smp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               push,
  input logic               full,
  input smp_pkg::in_item_t   item_i,
  input logic               empty,
  input logic               pop,
  input smp_pkg::out_item_t  item_o
);
  import smp_pkg::*;

  // The final word always closes a block.
  a_end_closes_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && item_o.message_end) |-> item_o.block_end)
    else $error("message_end without block_end");

  // The length word counts whole bytes, so its low three bits are zero.
  a_len_byte_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && item_o.message_end) |-> (item_o.word_out[2:0] == 3'b000))
    else $error("length word not a multiple of 8");

  // The input queue fills only through a push.
  a_full_after_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(push))
    else $error("full rose without a push");

  // A waiting result holds until it is taken.
  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(item_o)))
    else $error("waiting result changed");

endmodule

bind sha256_message_padder smp_checker u_smp_checker (.*);
